/* hdl/spr_pkg.sv */
// Shared types and constants of the sample pack record scanner.
package spr_pkg;

  // Container tags as they sit in the upper word of the byte history
  localparam logic [31:0] TAG_FORM = 32'h4D52_4F46;
  localparam logic [31:0] TAG_SOND = 32'h444E_4F53;
  localparam logic [31:0] TAG_DIGI = 32'h4947_4944;

  // Record markers that mark a usable record
  localparam logic [15:0] MARK_A = 16'hEAEA;
  localparam logic [15:0] MARK_B = 16'hDEAF;

  // Byte positions that close each checked header tag
  localparam logic [31:0] POS_FORM_OUTER = 32'd3;
  localparam logic [31:0] POS_SOND_OUTER = 32'd11;
  localparam logic [31:0] POS_FORM_INNER = 32'd15;
  localparam logic [31:0] POS_DIGI       = 32'd23;
  localparam logic [31:0] POS_SOND_INNER = 32'd27;
  localparam logic [31:0] POS_HDR_END    = 32'd31;

  localparam logic [31:0] HDR_BYTES      = 32'd32;
  localparam logic [31:0] REC_HDR_BYTES  = 32'd8;
  localparam logic [31:0] MIN_FIRST_REC  = 32'd40;

  localparam int          COUNT_W   = 30;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result queue depth: room for the two results one byte can raise
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_RECHDR = 4'b0010,
    PH_SKIP   = 4'b0100,
    PH_DONE   = 4'b1000
  } spr_phase_t;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_STATUS = 1'b1
  } spr_kind_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_NONE    = 2'd2
  } spr_status_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        sample_index;
    logic [31:0]        data_offset;
    logic [31:0]        data_size;
    logic [1:0]         scan_status;
    logic               stopped_early;
    logic [COUNT_W-1:0] record_count;
    logic               last;
  } spr_result_t;

endpackage

/* hdl/spr_if.sv */
// Channel interfaces of the sample pack record scanner.
interface spr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface spr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] sample_index;
  logic [31:0] data_offset;
  logic [31:0] data_size;
  logic [1:0]  scan_status;
  logic        stopped_early;
  logic [29:0] record_count;
  logic        last;

  modport source (output valid, kind, sample_index, data_offset, data_size, scan_status,
                  stopped_early, record_count, last, input ready);
  modport sink   (input valid, kind, sample_index, data_offset, data_size, scan_status,
                  stopped_early, record_count, last, output ready);
endinterface

interface spr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_length;

  modport source (output valid, file_length, input ready);
  modport sink   (input valid, file_length, output ready);
endinterface

/* hdl/sample_pack_record_scanner_core.sv */
// Top level of the sample pack record scanner.
//
// Usage:
//   cfg_ch  : one beat writes file_length; always ready. Write it while idle.
//   in_ch   : one file byte per beat, last_byte set on the final byte.
//   out_ch  : record beats (kind 0) and one status beat (kind 1) after the
//             final byte; last marks the final beat raised by a byte.
// Each accepted byte is parsed in the cycle it is accepted: the parse state
// registers and the byte feed a short decode that writes zero, one or two
// result beats into a four-entry result queue. Each result beat reaches
// out_ch from the queue registers, behind any beats still queued.
// Throughput: one byte per cycle while the queue holds at most two beats;
// a byte that raises two beats drains as two output beats.
// When the receiver stalls the queue fills and in_ch.ready drops once fewer
// than two entries are free; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue, clears the parse state
// and sets file_length to zero. After the final byte the parse state returns
// to its reset value, so the next byte starts a new file.
module sample_pack_record_scanner_core (
  input  logic      clk,
  input  logic      rst_n,
  spr_cfg_if.sink   cfg_ch,
  spr_in_if.sink    in_ch,
  spr_out_if.source out_ch
);
  import spr_pkg::*;

  // Configuration and parse state
  logic [31:0]        file_len_r;
  logic [31:0]        pos_r,      pos_nxt;
  spr_phase_t         phase_r,    phase_nxt;
  logic [31:0]        pend_r,     pend_nxt;
  logic [63:0]        shift_r,    shift_nxt;
  logic [31:0]        skip_r,     skip_nxt;
  logic [COUNT_W-1:0] count_r,    count_nxt;
  logic               hdr_bad_r,  hdr_bad_nxt;
  logic               stopped_r,  stopped_nxt;

  // Result queue
  spr_result_t        rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0]   rq_wr_r, rq_rd_r;
  logic [RQ_AW:0]     rq_cnt_r;

  logic               in_fire, out_fire;
  logic [1:0]         n_res;
  spr_result_t        res_a, res_b;

  logic [31:0]        top;
  logic [31:0]        psize;
  logic [32:0]        pend_ext;
  logic [32:0]        pos1_ext;
  logic               start_ok;
  logic [33:0]        rec_end;
  logic [15:0]        mark;
  logic               rec;
  spr_result_t        rec_res, stat_res;
  spr_status_t        stat;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (rq_cnt_r <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;

  // Hold the file length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_len_r <= '0;
    end else if (cfg_ch.valid) begin
      file_len_r <= cfg_ch.file_length;
    end
  end

  // Parse one byte against the current state
  always_comb begin
    shift_nxt   = {in_ch.data_byte, shift_r[63:8]};
    top         = shift_nxt[63:32];
    psize       = {top[7:0], top[15:8], top[23:16], top[31:24]};
    pend_ext    = {1'b0, psize} + {1'b0, HDR_BYTES};
    pos1_ext    = {1'b0, pos_r} + 33'd1;
    start_ok    = (pos1_ext + {1'b0, REC_HDR_BYTES}) <= {1'b0, pend_r};
    rec_end     = {1'b0, pos1_ext} + {2'b00, top};
    mark        = shift_nxt[31:16];
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    skip_nxt    = skip_r;
    count_nxt   = count_r;
    hdr_bad_nxt = hdr_bad_r;
    stopped_nxt = stopped_r;
    pos_nxt     = pos_r + 32'd1;
    rec         = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if ((pos_r == POS_FORM_OUTER || pos_r == POS_FORM_INNER) && top != TAG_FORM) begin
          hdr_bad_nxt = 1'b1;
        end
        if ((pos_r == POS_SOND_OUTER || pos_r == POS_SOND_INNER) && top != TAG_SOND) begin
          hdr_bad_nxt = 1'b1;
        end
        if (pos_r == POS_DIGI && top != TAG_DIGI) begin
          hdr_bad_nxt = 1'b1;
        end
        if (pos_r >= POS_HDR_END) begin
          if (file_len_r < HDR_BYTES) begin
            hdr_bad_nxt = 1'b1;
          end
          if (hdr_bad_nxt) begin
            phase_nxt = PH_DONE;
          end else begin
            pend_nxt = (pend_ext < {1'b0, file_len_r}) ? pend_ext[31:0] : file_len_r;
            // first record header fits when both bounds reach past it
            if (psize >= REC_HDR_BYTES && file_len_r >= MIN_FIRST_REC) begin
              phase_nxt = PH_RECHDR;
              skip_nxt  = REC_HDR_BYTES;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
      PH_RECHDR: begin
        if (skip_r > 32'd1) begin
          skip_nxt = skip_r - 32'd1;
        end else if ((mark != MARK_A && mark != MARK_B) ||
                     rec_end > {2'b00, pend_r}) begin
          stopped_nxt = 1'b1;
          phase_nxt   = PH_DONE;
        end else begin
          rec = 1'b1;
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
          if (top == 32'd0) begin
            if (start_ok) begin
              phase_nxt = PH_RECHDR;
              skip_nxt  = REC_HDR_BYTES;
            end else begin
              phase_nxt = PH_DONE;
            end
          end else begin
            phase_nxt = PH_SKIP;
            skip_nxt  = top;
          end
        end
      end
      PH_SKIP: begin
        if (skip_r > 32'd1) begin
          skip_nxt = skip_r - 32'd1;
        end else if (start_ok) begin
          phase_nxt = PH_RECHDR;
          skip_nxt  = REC_HDR_BYTES;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // Build the record beat and the status beat
    if (hdr_bad_nxt || phase_nxt == PH_HEADER) begin
      stat = ST_BAD_HDR;
    end else if (count_nxt == '0) begin
      stat = ST_NONE;
    end else begin
      stat = ST_FOUND;
    end

    rec_res.kind          = KIND_RECORD;
    rec_res.sample_index  = shift_nxt[15:0];
    rec_res.data_offset   = pos1_ext[31:0];
    rec_res.data_size     = top;
    rec_res.scan_status   = ST_FOUND;
    rec_res.stopped_early = 1'b0;
    rec_res.record_count  = count_nxt;
    rec_res.last          = !in_ch.last_byte;

    stat_res.kind          = KIND_STATUS;
    stat_res.sample_index  = '0;
    stat_res.data_offset   = '0;
    stat_res.data_size     = '0;
    stat_res.scan_status   = stat;
    stat_res.stopped_early = stopped_nxt;
    stat_res.record_count  = count_nxt;
    stat_res.last          = 1'b1;

    res_a = rec ? rec_res : stat_res;
    res_b = stat_res;
    n_res = {1'b0, rec} + {1'b0, in_ch.last_byte};

    // Drop all parse state after the final byte
    if (in_ch.last_byte) begin
      pos_nxt     = '0;
      phase_nxt   = PH_HEADER;
      pend_nxt    = '0;
      shift_nxt   = '0;
      skip_nxt    = '0;
      count_nxt   = '0;
      hdr_bad_nxt = 1'b0;
      stopped_nxt = 1'b0;
    end
  end

  // Advance the parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= PH_HEADER;
      pend_r    <= '0;
      shift_r   <= '0;
      skip_r    <= '0;
      count_r   <= '0;
      hdr_bad_r <= 1'b0;
      stopped_r <= 1'b0;
    end else if (in_fire) begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      pend_r    <= pend_nxt;
      shift_r   <= shift_nxt;
      skip_r    <= skip_nxt;
      count_r   <= count_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // Write result beats into the queue
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      rq_mem[rq_wr_r] <= res_a;
    end
    if (in_fire && n_res == 2'd2) begin
      rq_mem[rq_wr_r + 1'b1] <= res_b;
    end
  end

  // Track queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (in_fire) begin
        rq_wr_r <= rq_wr_r + RQ_AW'(n_res);
      end
      if (out_fire) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
      rq_cnt_r <= rq_cnt_r + (in_fire ? (RQ_AW+1)'(n_res) : '0)
                           - (RQ_AW+1)'(out_fire);
    end
  end

  // Present the head of the queue
  assign out_ch.valid         = (rq_cnt_r != '0);
  assign out_ch.kind          = rq_mem[rq_rd_r].kind;
  assign out_ch.sample_index  = rq_mem[rq_rd_r].sample_index;
  assign out_ch.data_offset   = rq_mem[rq_rd_r].data_offset;
  assign out_ch.data_size     = rq_mem[rq_rd_r].data_size;
  assign out_ch.scan_status   = rq_mem[rq_rd_r].scan_status;
  assign out_ch.stopped_early = rq_mem[rq_rd_r].stopped_early;
  assign out_ch.record_count  = rq_mem[rq_rd_r].record_count;
  assign out_ch.last          = rq_mem[rq_rd_r].last;

endmodule

/* hdl/spr_checker.sv */
// Port-level checks of the sample pack record scanner and their binding.
module spr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [31:0] data_offset,
  input logic [1:0]  scan_status,
  input logic        stopped_early,
  input logic [29:0] record_count,
  input logic        last
);
  import spr_pkg::*;

  // Empty the queue on reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // Hold a stalled beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_offset)
                                 && $stable(record_count))
    else $error("stalled result beat changed");

  // A status beat always closes the beats of its byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_STATUS |-> last)
    else $error("status beat without last");

  // Record beats carry no status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_RECORD |-> scan_status == ST_FOUND && !stopped_early)
    else $error("record beat carries status bits");

  // Bad header or empty scan means no record was counted
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_STATUS && scan_status != ST_FOUND |-> record_count == '0)
    else $error("failed scan reports records");

endmodule

bind sample_pack_record_scanner_core spr_checker u_spr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .kind          (out_ch.kind),
  .data_offset   (out_ch.data_offset),
  .scan_status   (out_ch.scan_status),
  .stopped_early (out_ch.stopped_early),
  .record_count  (out_ch.record_count),
  .last          (out_ch.last)
);
